@@ rtl/dtlp_pkg.sv @@
// types and constants shared by the date/time line parser
// no dependencies; imported by dtlp_scan and datetime_line_parser
package dtlp_pkg;

    localparam int AccW = 12;
    localparam logic [AccW-1:0] AccMax = 12'd4095;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_USE_RTC     = 4'd1,
        ST_TIME_FMT    = 4'd2,
        ST_DATE_FMT    = 4'd3,
        ST_YEAR_FMT    = 4'd4,
        ST_TIME_RANGE  = 4'd5,
        ST_MONTH       = 4'd6,
        ST_YEAR_ZERO   = 4'd7,
        ST_PRE_EPOCH   = 4'd8,
        ST_PRE_FLOOR   = 4'd9,
        ST_POST_CEIL   = 4'd10,
        ST_DAY         = 4'd11
    } status_t;

    typedef enum logic [5:0] {
        PH_HOUR = 6'b000001,
        PH_MIN  = 6'b000010,
        PH_DAY  = 6'b000100,
        PH_MON  = 6'b001000,
        PH_YEAR = 6'b010000,
        PH_TAIL = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        REG_EPOCH   = 2'd0,
        REG_FLOOR   = 2'd1,
        REG_CEILING = 2'd2
    } reg_index_t;

    // fields captured when a line ends, ready for the range checks
    typedef struct packed {
        status_t         pre;
        logic [AccW-1:0] hour;
        logic [AccW-1:0] minute;
        logic [AccW-1:0] day;
        logic [AccW-1:0] month;
        logic [AccW-1:0] year;
        logic [7:0]      year_q25;
    } line_snap_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/dtlp_scan.sv @@
// character scanner: accumulates digits, checks separators, tracks the field
// depends on dtlp_pkg; produces the end-of-line snapshot for the top level
module dtlp_scan
    import dtlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] ch,
    output line_snap_t snap
);

    phase_t          phase_reg, phase_next;
    logic            line_start_reg, line_start_next;
    logic [AccW-1:0] acc_reg, acc_next;
    logic            seen_reg, seen_next;
    status_t         err_reg, err_next;
    logic [AccW-1:0] p_hour_reg, p_hour_next;
    logic [AccW-1:0] p_min_reg, p_min_next;
    logic [AccW-1:0] p_day_reg, p_day_next;
    logic [AccW-1:0] p_mon_reg, p_mon_next;

    logic            is_digit;
    logic [3:0]      digit;
    logic [15:0]     acc_x10;
    logic [15:0]     acc_sum;
    logic [AccW-1:0] acc_sat;
    logic [7:0]      sep;
    status_t         fmt;
    logic [22:0]     q_prod;

    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign digit    = ch[3:0];
    assign acc_x10  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
    assign acc_sum  = acc_x10 + {12'd0, digit};
    assign acc_sat  = (acc_sum > {4'd0, AccMax}) ? AccMax : acc_sum[AccW-1:0];

    always_comb
    begin
        unique case (phase_reg)
            PH_HOUR:
            begin
                sep = 8'h3A;
                fmt = ST_TIME_FMT;
            end
            PH_MIN:
            begin
                sep = 8'h20;
                fmt = ST_TIME_FMT;
            end
            PH_DAY, PH_MON:
            begin
                sep = 8'h2D;
                fmt = ST_DATE_FMT;
            end
            default:
            begin
                sep = 8'h2D;
                fmt = ST_YEAR_FMT;
            end
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        line_start_next = line_start_reg;
        acc_next        = acc_reg;
        seen_next       = seen_reg;
        err_next        = err_reg;
        p_hour_next     = p_hour_reg;
        p_min_next      = p_min_reg;
        p_day_next      = p_day_reg;
        p_mon_next      = p_mon_reg;
        if (take)
        begin
            if (ch == 8'h00)
            begin
                phase_next      = PH_HOUR;
                line_start_next = 1'b1;
                acc_next        = '0;
                seen_next       = 1'b0;
                err_next        = ST_OK;
                p_hour_next     = '0;
                p_min_next      = '0;
                p_day_next      = '0;
                p_mon_next      = '0;
            end
            else
            begin
                line_start_next = 1'b0;
                if (err_reg == ST_OK && phase_reg != PH_TAIL)
                begin
                    priority if (is_digit)
                    begin
                        acc_next  = acc_sat;
                        seen_next = 1'b1;
                    end
                    else if (phase_reg == PH_YEAR)
                    begin
                        if (!seen_reg)
                        begin
                            err_next = ST_YEAR_FMT;
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                    else if (!seen_reg || ch != sep)
                    begin
                        err_next = fmt;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_HOUR:
                            begin
                                p_hour_next = acc_reg;
                                phase_next  = PH_MIN;
                            end
                            PH_MIN:
                            begin
                                p_min_next = acc_reg;
                                phase_next = PH_DAY;
                            end
                            PH_DAY:
                            begin
                                p_day_next = acc_reg;
                                phase_next = PH_MON;
                            end
                            default:
                            begin
                                p_mon_next = acc_reg;
                                phase_next = PH_YEAR;
                            end
                        endcase
                        acc_next  = '0;
                        seen_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HOUR;
            line_start_reg <= 1'b1;
            acc_reg        <= '0;
            seen_reg       <= 1'b0;
            err_reg        <= ST_OK;
            p_hour_reg     <= '0;
            p_min_reg      <= '0;
            p_day_reg      <= '0;
            p_mon_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            line_start_reg <= line_start_next;
            acc_reg        <= acc_next;
            seen_reg       <= seen_next;
            err_reg        <= err_next;
            p_hour_reg     <= p_hour_next;
            p_min_reg      <= p_min_next;
            p_day_reg      <= p_day_next;
            p_mon_reg      <= p_mon_next;
        end
    end

    // year / 25 by reciprocal, exact for 12-bit years
    assign q_prod = {11'd0, acc_reg} * 23'd1311;

    always_comb
    begin
        snap.hour     = p_hour_reg;
        snap.minute   = p_min_reg;
        snap.day      = p_day_reg;
        snap.month    = p_mon_reg;
        snap.year     = acc_reg;
        snap.year_q25 = q_prod[22:15];
        priority if (line_start_reg)
        begin
            snap.pre = ST_USE_RTC;
        end
        else if (err_reg != ST_OK)
        begin
            snap.pre = err_reg;
        end
        else if (phase_reg == PH_HOUR || phase_reg == PH_MIN)
        begin
            snap.pre = ST_TIME_FMT;
        end
        else if (phase_reg == PH_DAY || phase_reg == PH_MON)
        begin
            snap.pre = ST_DATE_FMT;
        end
        else if (phase_reg == PH_YEAR && !seen_reg)
        begin
            snap.pre = ST_YEAR_FMT;
        end
        else
        begin
            snap.pre = ST_OK;
        end
    end

    property p_tail_has_digits;
        @(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TAIL |-> (err_reg == ST_OK && !line_start_reg);
    endproperty
    a_tail_has_digits: assert property (p_tail_has_digits)
        else $error("tail phase with latched error or at line start");

    property p_eol_clears;
        @(posedge clk) disable iff (!rst_n)
        take && ch == 8'h00 |=> line_start_reg && phase_reg == PH_HOUR && !seen_reg;
    endproperty
    a_eol_clears: assert property (p_eol_clears)
        else $error("parse state not cleared after end of line");

    property p_line_start_clean;
        @(posedge clk) disable iff (!rst_n)
        line_start_reg |-> (acc_reg == '0 && err_reg == ST_OK);
    endproperty
    a_line_start_clean: assert property (p_line_start_clean)
        else $error("line start with leftover parse state");

endmodule

@@ rtl/datetime_line_parser.sv @@
// top level of the date/time line parser: flow control, limit registers,
// range checks and held date/time; depends on dtlp_pkg and dtlp_scan
//
// Usage:
//   char channel (ch, char_valid, char_stall) carries one console character
//   per transaction; a zero character ends the line. Digits are accumulated
//   and separators of "HH:MM DD-MM-YYYY" are checked as they arrive.
//   result channel (status, hour..year, result_valid, result_stall) carries
//   one transaction per line end: the status code and the held date/time,
//   which a line with status ok replaces.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
//   epoch, floor and ceiling year limits; cfg_ready is always high and an
//   unknown index is ignored. Write only while the block is idle.
// Flow:
//   one character is accepted every cycle unless char_stall is high. A result
//   is registered from its end-of-line character into the snapshot register,
//   then passes through the range checks into the result register.
//   When result_stall holds the result register and the snapshot register
//   is also full, char_stall rises until the result is taken.
// Reset:
//   limits return to 1971 / 2026 / 3000, held time to 00:00 01-01-2026,
//   and the parser starts at the hour field of an empty line.
module datetime_line_parser
    import dtlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  ch,
    input  logic        char_valid,
    output logic        char_stall,
    output logic [3:0]  status,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [4:0]  day,
    output logic [3:0]  month,
    output logic [11:0] year,
    output logic        result_valid,
    input  logic        result_stall,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    line_snap_t      snap;
    line_snap_t      fin_reg;
    logic            fin_valid_reg, fin_valid_next;
    logic            res_valid_reg, res_valid_next;
    status_t         status_reg;
    status_t         chk;
    logic [AccW-1:0] epoch_reg, floor_reg, ceil_reg;
    logic [4:0]      held_hour_reg;
    logic [5:0]      held_min_reg;
    logic [4:0]      held_day_reg;
    logic [3:0]      held_mon_reg;
    logic [11:0]     held_year_reg;

    logic            take;
    logic            take_eol;
    logic            res_free;
    logic            fin_move;
    logic            cfg_we;
    logic [12:0]     q_x25;
    logic            div25;
    logic            leap;
    logic [4:0]      max_day;

    assign res_free   = !res_valid_reg || !result_stall;
    assign fin_move   = fin_valid_reg && res_free;
    assign char_stall = fin_valid_reg && !res_free;
    assign take       = char_valid && !char_stall;
    assign take_eol   = take && (ch == 8'h00);
    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;

    dtlp_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .ch    (ch),
        .snap  (snap)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= 12'd1971;
            floor_reg <= 12'd2026;
            ceil_reg  <= 12'd3000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EPOCH:   epoch_reg <= cfg_data;
                REG_FLOOR:   floor_reg <= cfg_data;
                REG_CEILING: ceil_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // gregorian leap test: divisible by 4, and by 16 when divisible by 25
    assign q_x25   = {1'b0, fin_reg.year_q25, 4'b0000} + {2'b00, fin_reg.year_q25, 3'b000}
                   + {5'd0, fin_reg.year_q25};
    assign div25   = (q_x25 == {1'b0, fin_reg.year});
    assign leap    = (fin_reg.year[1:0] == 2'b00) && (!div25 || fin_reg.year[3:0] == 4'd0);
    assign max_day = (fin_reg.month[3:0] == 4'd2 && leap) ? 5'd29
                   : month_len(fin_reg.month[3:0]);

    always_comb
    begin
        priority if (fin_reg.pre != ST_OK)
        begin
            chk = fin_reg.pre;
        end
        else if (fin_reg.hour > 12'd23 || fin_reg.minute > 12'd59)
        begin
            chk = ST_TIME_RANGE;
        end
        else if (fin_reg.month < 12'd1 || fin_reg.month > 12'd12)
        begin
            chk = ST_MONTH;
        end
        else if (fin_reg.year == '0)
        begin
            chk = ST_YEAR_ZERO;
        end
        else if (fin_reg.year < epoch_reg)
        begin
            chk = ST_PRE_EPOCH;
        end
        else if (fin_reg.year < floor_reg)
        begin
            chk = ST_PRE_FLOOR;
        end
        else if (fin_reg.year > ceil_reg)
        begin
            chk = ST_POST_CEIL;
        end
        else if (fin_reg.day < 12'd1 || fin_reg.day > {7'd0, max_day})
        begin
            chk = ST_DAY;
        end
        else
        begin
            chk = ST_OK;
        end
    end

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (take_eol)
        begin
            fin_valid_next = 1'b1;
        end
        else if (fin_move)
        begin
            fin_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fin_move)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            held_hour_reg <= 5'd0;
            held_min_reg  <= 6'd0;
            held_day_reg  <= 5'd1;
            held_mon_reg  <= 4'd1;
            held_year_reg <= 12'd2026;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            res_valid_reg <= res_valid_next;
            if (fin_move && chk == ST_OK)
            begin
                held_hour_reg <= fin_reg.hour[4:0];
                held_min_reg  <= fin_reg.minute[5:0];
                held_day_reg  <= fin_reg.day[4:0];
                held_mon_reg  <= fin_reg.month[3:0];
                held_year_reg <= fin_reg.year;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_eol)
        begin
            fin_reg <= snap;
        end
        if (fin_move)
        begin
            status_reg <= chk;
        end
    end

    // held values only change when a result is loaded, so they stay put
    // while the result register is stalled
    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign hour         = held_hour_reg;
    assign minute       = held_min_reg;
    assign day          = held_day_reg;
    assign month        = held_mon_reg;
    assign year         = held_year_reg;

    property p_held_time_range;
        @(posedge clk) disable iff (!rst_n)
        held_hour_reg <= 5'd23 && held_min_reg <= 6'd59;
    endproperty
    a_held_time_range: assert property (p_held_time_range)
        else $error("held time out of range");

    property p_held_date_range;
        @(posedge clk) disable iff (!rst_n)
        held_mon_reg >= 4'd1 && held_mon_reg <= 4'd12 && held_day_reg >= 5'd1
            && held_year_reg != 12'd0;
    endproperty
    a_held_date_range: assert property (p_held_date_range)
        else $error("held date out of range");

    property p_commit_on_ok;
        @(posedge clk) disable iff (!rst_n)
        fin_move && chk == ST_OK |=> held_year_reg == $past(fin_reg.year)
            && status_reg == ST_OK && res_valid_reg;
    endproperty
    a_commit_on_ok: assert property (p_commit_on_ok)
        else $error("valid line did not update held date");

    property p_stall_only_when_full;
        @(posedge clk) disable iff (!rst_n)
        char_stall |-> fin_valid_reg && res_valid_reg && result_stall;
    endproperty
    a_stall_only_when_full: assert property (p_stall_only_when_full)
        else $error("char channel stalled with room in the pipeline");

    property p_held_stable_on_fail;
        @(posedge clk) disable iff (!rst_n)
        !(fin_move && chk == ST_OK) |=> $stable(held_year_reg) && $stable(held_day_reg);
    endproperty
    a_held_stable_on_fail: assert property (p_held_stable_on_fail)
        else $error("held date changed without a valid line");

endmodule
